>>> rtl/zfl_pkg.sv
// Package for the zstd frame length walker: phase and error codes, request and
// result structs, header constants and the content size field decode.
// No dependencies.
package zfl_pkg;

  localparam int LENGTH_BITS = 40;
  localparam int OUT_LEN_W   = 40;
  localparam int BLK_CNT_W   = 20;
  localparam int SKIP_W      = 18;
  localparam int BSIZE_W     = 21;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX        = {LENGTH_BITS{1'b1}};
  localparam logic [OUT_LEN_W-1:0]   CONSUMED_MAX   = {OUT_LEN_W{1'b1}};
  localparam logic [BLK_CNT_W-1:0]   MAX_BLOCKS     = BLK_CNT_W'(1000000);
  localparam logic [BSIZE_W-1:0]     MAX_BLOCK_SIZE = BSIZE_W'(131072);
  localparam logic [63:0]            FCS_LIMIT      = 64'h4000_0000_0000_0000;
  localparam logic [63:0]            FCS_BIAS_1     = 64'd1;
  localparam logic [63:0]            FCS_BIAS_2     = 64'd256;
  localparam logic [63:0]            FCS_BIAS_4     = 64'd65536;

  localparam int HDR_CHECKSUM_BIT = 2;
  localparam int HDR_DICT_BIT     = 3;
  localparam int HDR_RESERVED_BIT = 4;
  localparam int HDR_SINGLE_BIT   = 5;

  localparam logic [3:0] MAGIC_LEN  = 4'd4;
  localparam logic [3:0] BHDR_LEN   = 4'd3;
  localparam logic [3:0] CSUM_LEN   = 4'd4;

  localparam logic [1:0] FCS_FLAG_2 = 2'd1;
  localparam logic [1:0] FCS_FLAG_4 = 2'd2;
  localparam logic [1:0] FCS_FLAG_8 = 2'd3;

  localparam logic [1:0] BT_RAW      = 2'd0;
  localparam logic [1:0] BT_RLE      = 2'd1;
  localparam logic [1:0] BT_COMP     = 2'd2;
  localparam logic [1:0] BT_RESERVED = 2'd3;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_MAGIC = 4'd1,
    PH_FHD   = 4'd2,
    PH_WIN   = 4'd3,
    PH_FCS   = 4'd4,
    PH_BHDR  = 4'd5,
    PH_BODY  = 4'd6,
    PH_CSUM  = 4'd7
  } phase_t;

  typedef enum logic [2:0] {
    ERR_OK            = 3'd0,
    ERR_HEADER        = 3'd1,
    ERR_TRUNC         = 3'd2,
    ERR_RESERVED      = 3'd3,
    ERR_BLOCK_SIZE    = 3'd4,
    ERR_SIZE_MISMATCH = 3'd5,
    ERR_BLOCK_COUNT   = 3'd6,
    ERR_FCS_LIMIT     = 3'd7
  } err_t;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] data_byte;
    logic       data_end;
  } item_t;

  typedef struct packed {
    logic                 frame_ok;
    logic [OUT_LEN_W-1:0] frame_length;
    err_t                 error_code;
  } result_t;

  function automatic logic [3:0] fcs_bytes(input logic [7:0] f);
    logic [3:0] n;
    case (f[7:6])
      FCS_FLAG_2: n = 4'd2;
      FCS_FLAG_4: n = 4'd4;
      FCS_FLAG_8: n = 4'd8;
      default:    n = (f[HDR_SINGLE_BIT] && !f[HDR_DICT_BIT]) ? 4'd1 : 4'd0;
    endcase
    return n;
  endfunction

endpackage

>>> rtl/zfl_ifs.sv
// Handshake channels of the zstd frame length walker: byte request in, result out.
// Depends on zfl_pkg.
interface zfl_in_if;
  logic       valid;
  logic       ready;
  logic       frame_start;
  logic [7:0] data_byte;
  logic       data_end;

  modport source(output valid, frame_start, data_byte, data_end, input ready);
  modport sink(input valid, frame_start, data_byte, data_end, output ready);
endinterface

interface zfl_out_if;
  logic                          valid;
  logic                          ready;
  logic                          frame_ok;
  logic [zfl_pkg::OUT_LEN_W-1:0] frame_length;
  logic [2:0]                    error_code;

  modport source(output valid, frame_ok, frame_length, error_code, input ready);
  modport sink(input valid, frame_ok, frame_length, error_code, output ready);
endinterface

>>> rtl/zstd_frame_length_walker_top.sv
// zstd frame length walker: one frame byte per request, one result per frame.
// out_ch.valid is registered in u_out; the last request of a frame first waits in u_in.
// Throughput: one byte per cycle; a result waiting at the output stalls the input.
// Reset: synchronous, active low; the walker returns to idle and waits for frame_start.
// Depends on zfl_pkg, zfl_ifs, zfl_in_stage, zfl_core, zfl_out_stage.
module zstd_frame_length_walker_top (
  input  logic       clk,
  input  logic       rst_n,
  zfl_in_if.sink     in_ch,
  zfl_out_if.source  out_ch
);

  logic             item_valid;
  zfl_pkg::item_t   item;
  logic             can_take;
  logic             advance;
  logic             res_valid;
  zfl_pkg::result_t res;

  assign advance = item_valid && can_take;

  zfl_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  zfl_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  zfl_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .can_take  (can_take),
    .out_ch    (out_ch)
  );

endmodule

>>> rtl/zfl_in_stage.sv
// Input register of the frame walker: holds one accepted byte request.
// Depends on zfl_pkg and zfl_in_if.
module zfl_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  zfl_in_if.sink             in_ch,
  input  logic               advance,
  output logic               item_valid,
  output zfl_pkg::item_t     item
);

  logic           valid_r;
  logic           valid_nxt;
  zfl_pkg::item_t item_r;

  assign in_ch.ready = !valid_r || advance;
  assign valid_nxt   = (in_ch.valid && in_ch.ready) ? 1'b1 : (advance ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r <= '{frame_start: in_ch.frame_start, data_byte: in_ch.data_byte,
                  data_end: in_ch.data_end};
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

>>> rtl/zfl_core.sv
// Frame walker state and per-byte step logic: header checks, block walk, result code.
// Depends on zfl_pkg.
module zfl_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  zfl_pkg::item_t      item,
  output logic                res_valid,
  output zfl_pkg::result_t    res
);

  zfl_pkg::phase_t                     phase_r, phase_nxt;
  logic [zfl_pkg::LENGTH_BITS-1:0]     pos_r, pos_nxt;
  logic [7:0]                          flags_r, flags_nxt;
  logic [63:0]                         csize_r, csize_nxt;
  logic [3:0]                          fcnt_r, fcnt_nxt;
  logic [23:0]                         bhdr_r, bhdr_nxt;
  logic [zfl_pkg::SKIP_W-1:0]          skip_r, skip_nxt;
  logic [zfl_pkg::OUT_LEN_W-1:0]       consumed_r, consumed_nxt;
  logic [zfl_pkg::BLK_CNT_W-1:0]       blocks_r, blocks_nxt;
  logic                                seen_r, seen_nxt;
  logic                                rc_hit;
  zfl_pkg::err_t                       rc_code;

  always_comb begin
    zfl_pkg::phase_t             cur_ph;
    logic [zfl_pkg::OUT_LEN_W:0] sum_w;
    logic [zfl_pkg::BSIZE_W-1:0] bsize;
    logic [1:0]                  btype;
    logic                        live;
    logic                        done_hit;
    logic                        fin_hit;

    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    flags_nxt    = flags_r;
    csize_nxt    = csize_r;
    fcnt_nxt     = fcnt_r;
    bhdr_nxt     = bhdr_r;
    skip_nxt     = skip_r;
    consumed_nxt = consumed_r;
    blocks_nxt   = blocks_r;
    seen_nxt     = seen_r;
    cur_ph       = zfl_pkg::PH_IDLE;
    sum_w        = '0;
    bsize        = '0;
    btype        = zfl_pkg::BT_RAW;
    live         = 1'b0;
    rc_hit       = 1'b0;
    done_hit     = 1'b0;
    fin_hit      = 1'b0;
    rc_code      = zfl_pkg::ERR_OK;

    if (advance) begin
      if (item.frame_start) begin
        phase_nxt    = zfl_pkg::PH_MAGIC;
        pos_nxt      = '0;
        flags_nxt    = '0;
        csize_nxt    = '0;
        fcnt_nxt     = '0;
        bhdr_nxt     = '0;
        skip_nxt     = '0;
        consumed_nxt = '0;
        blocks_nxt   = '0;
        seen_nxt     = 1'b0;
      end
      cur_ph = phase_nxt;
      if (cur_ph != zfl_pkg::PH_IDLE) begin
        if (pos_nxt == zfl_pkg::LEN_MAX) begin
          rc_hit  = 1'b1;
          rc_code = zfl_pkg::ERR_TRUNC;
        end else begin
          pos_nxt = pos_nxt + 1'b1;
          live    = 1'b1;
          unique case (cur_ph)
            zfl_pkg::PH_MAGIC: begin
              fcnt_nxt = fcnt_nxt + 1'b1;
              if (fcnt_nxt >= zfl_pkg::MAGIC_LEN) phase_nxt = zfl_pkg::PH_FHD;
            end
            zfl_pkg::PH_FHD: begin
              if (item.data_byte == 8'd0 || item.data_byte[zfl_pkg::HDR_RESERVED_BIT] ||
                  item.data_byte[1:0] != 2'd0) begin
                rc_hit  = 1'b1;
                rc_code = zfl_pkg::ERR_HEADER;
              end else begin
                flags_nxt = item.data_byte;
                fcnt_nxt  = '0;
                if (!item.data_byte[zfl_pkg::HDR_SINGLE_BIT]) phase_nxt = zfl_pkg::PH_WIN;
                else if (zfl_pkg::fcs_bytes(item.data_byte) != 4'd0)
                  phase_nxt = zfl_pkg::PH_FCS;
                else phase_nxt = zfl_pkg::PH_BHDR;
              end
            end
            zfl_pkg::PH_WIN: begin
              phase_nxt = (zfl_pkg::fcs_bytes(flags_nxt) != 4'd0) ?
                          zfl_pkg::PH_FCS : zfl_pkg::PH_BHDR;
            end
            zfl_pkg::PH_FCS: begin
              csize_nxt[8*fcnt_nxt[2:0] +: 8] = csize_nxt[8*fcnt_nxt[2:0] +: 8] |
                                                 item.data_byte;
              fcnt_nxt = fcnt_nxt + 1'b1;
              if (fcnt_nxt >= zfl_pkg::fcs_bytes(flags_nxt)) begin
                if (zfl_pkg::fcs_bytes(flags_nxt) == 4'd1)
                  csize_nxt = csize_nxt + zfl_pkg::FCS_BIAS_1;
                else if (flags_nxt[7:6] == zfl_pkg::FCS_FLAG_2)
                  csize_nxt = csize_nxt + zfl_pkg::FCS_BIAS_2;
                else if (flags_nxt[7:6] == zfl_pkg::FCS_FLAG_4)
                  csize_nxt = csize_nxt + zfl_pkg::FCS_BIAS_4;
                if (csize_nxt > zfl_pkg::FCS_LIMIT) begin
                  rc_hit  = 1'b1;
                  rc_code = zfl_pkg::ERR_FCS_LIMIT;
                end else begin
                  phase_nxt = zfl_pkg::PH_BHDR;
                  fcnt_nxt  = '0;
                  bhdr_nxt  = '0;
                end
              end
            end
            zfl_pkg::PH_BHDR: begin
              case (fcnt_nxt[1:0])
                2'd0:    bhdr_nxt[7:0]   = bhdr_nxt[7:0]   | item.data_byte;
                2'd1:    bhdr_nxt[15:8]  = bhdr_nxt[15:8]  | item.data_byte;
                2'd2:    bhdr_nxt[23:16] = bhdr_nxt[23:16] | item.data_byte;
                default: bhdr_nxt        = bhdr_nxt;
              endcase
              fcnt_nxt = fcnt_nxt + 1'b1;
              if (fcnt_nxt >= zfl_pkg::BHDR_LEN) begin
                btype = bhdr_nxt[2:1];
                bsize = bhdr_nxt[23:3];
                if (btype == zfl_pkg::BT_RESERVED) begin
                  rc_hit  = 1'b1;
                  rc_code = zfl_pkg::ERR_RESERVED;
                end else if (bsize > zfl_pkg::MAX_BLOCK_SIZE) begin
                  rc_hit  = 1'b1;
                  rc_code = zfl_pkg::ERR_BLOCK_SIZE;
                end else begin
                  if (btype == zfl_pkg::BT_COMP) seen_nxt = 1'b1;
                  sum_w = {1'b0, consumed_nxt} +
                          (zfl_pkg::OUT_LEN_W + 1)'(bsize);
                  consumed_nxt = sum_w[zfl_pkg::OUT_LEN_W] ? zfl_pkg::CONSUMED_MAX :
                                 sum_w[zfl_pkg::OUT_LEN_W-1:0];
                  skip_nxt = (btype == zfl_pkg::BT_RLE) ? zfl_pkg::SKIP_W'(1) :
                             bsize[zfl_pkg::SKIP_W-1:0];
                  if (skip_nxt == '0) done_hit = 1'b1;
                  else phase_nxt = zfl_pkg::PH_BODY;
                end
              end
            end
            zfl_pkg::PH_BODY: begin
              skip_nxt = skip_nxt - 1'b1;
              if (skip_nxt == '0) done_hit = 1'b1;
            end
            zfl_pkg::PH_CSUM: begin
              fcnt_nxt = fcnt_nxt + 1'b1;
              if (fcnt_nxt >= zfl_pkg::CSUM_LEN) fin_hit = 1'b1;
            end
            default: begin
              phase_nxt = zfl_pkg::PH_IDLE;
              live      = 1'b0;
            end
          endcase

          if (done_hit) begin
            blocks_nxt = blocks_nxt + 1'b1;
            if (bhdr_nxt[0]) begin
              if (flags_nxt[zfl_pkg::HDR_CHECKSUM_BIT]) begin
                phase_nxt = zfl_pkg::PH_CSUM;
                fcnt_nxt  = '0;
              end else begin
                fin_hit = 1'b1;
              end
            end else if (blocks_nxt >= zfl_pkg::MAX_BLOCKS) begin
              rc_hit  = 1'b1;
              rc_code = zfl_pkg::ERR_BLOCK_COUNT;
            end else begin
              phase_nxt = zfl_pkg::PH_BHDR;
              fcnt_nxt  = '0;
              bhdr_nxt  = '0;
            end
          end

          if (fin_hit) begin
            rc_hit  = 1'b1;
            rc_code = (zfl_pkg::fcs_bytes(flags_nxt) != 4'd0 && !seen_nxt &&
                       {24'd0, consumed_nxt} != csize_nxt) ?
                      zfl_pkg::ERR_SIZE_MISMATCH : zfl_pkg::ERR_OK;
          end
        end

        if (!rc_hit && live && item.data_end) begin
          rc_hit  = 1'b1;
          rc_code = zfl_pkg::ERR_TRUNC;
        end
        if (rc_hit) phase_nxt = zfl_pkg::PH_IDLE;
      end
    end
  end

  always_comb begin
    res_valid = rc_hit;
    res = '{frame_ok:     (rc_code == zfl_pkg::ERR_OK),
            frame_length: (rc_code == zfl_pkg::ERR_OK) ?
                          zfl_pkg::OUT_LEN_W'(pos_nxt) : '0,
            error_code:   rc_code};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= zfl_pkg::PH_IDLE;
      pos_r      <= '0;
      flags_r    <= '0;
      csize_r    <= '0;
      fcnt_r     <= '0;
      bhdr_r     <= '0;
      skip_r     <= '0;
      consumed_r <= '0;
      blocks_r   <= '0;
      seen_r     <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      flags_r    <= flags_nxt;
      csize_r    <= csize_nxt;
      fcnt_r     <= fcnt_nxt;
      bhdr_r     <= bhdr_nxt;
      skip_r     <= skip_nxt;
      consumed_r <= consumed_nxt;
      blocks_r   <= blocks_nxt;
      seen_r     <= seen_nxt;
    end
  end

endmodule

>>> rtl/zfl_out_stage.sv
// Result register of the frame walker: holds one result until the sink takes it.
// Depends on zfl_pkg and zfl_out_if.
module zfl_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_valid,
  input  zfl_pkg::result_t   res,
  output logic               can_take,
  zfl_out_if.source          out_ch
);

  logic             valid_r;
  logic             valid_nxt;
  zfl_pkg::result_t res_r;

  assign can_take = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (valid_r && out_ch.ready) valid_nxt = 1'b0;
    if (can_take && res_valid) valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (can_take && res_valid) begin
      res_r <= res;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.frame_ok     = res_r.frame_ok;
  assign out_ch.frame_length = res_r.frame_length;
  assign out_ch.error_code   = res_r.error_code;

endmodule
